// ===== sv/kth_pkg.sv =====
`timescale 1ns / 1ps

package kth_pkg;

   // number of key slots and the span that one tick walks
   localparam int NUM_KEYS   = 16;
   localparam int KEY_SPAN   = 16;
   localparam int SLOT_COUNT = (NUM_KEYS < KEY_SPAN) ? NUM_KEYS : KEY_SPAN;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_DOWN   = 2'd1;
   localparam logic [1:0] OP_REPEAT = 2'd2;
   localparam logic [1:0] OP_UP     = 2'd3;

   // press kinds
   localparam logic [1:0] KIND_TAP    = 2'd0;
   localparam logic [1:0] KIND_REPEAT = 2'd1;
   localparam logic [1:0] KIND_HOLD   = 2'd2;

   // input item
   typedef struct packed {
      logic [1:0]         operation;
      logic [3:0]         key;
      logic [31:0]        now_ms;
      logic               policy_valid;
      logic               hold_enabled;
      logic               repeat_enabled;
      logic [7:0]         tap_action;
      logic signed [15:0] tap_value;
      logic [7:0]         hold_action;
      logic signed [15:0] hold_value;
      logic [15:0]        hold_threshold_ms;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0]         gesture;
      logic signed [15:0] gesture_value;
      logic [1:0]         press_kind;
      logic               last;
   } rsp_type;

   // stored per-key press record
   typedef struct packed {
      logic [31:0] press_start;
      logic [7:0]  tap_action;
      logic [15:0] tap_value;
      logic [7:0]  hold_action;
      logic [15:0] hold_value;
      logic [15:0] threshold;
   } slot_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic slot_write;
      logic emit_tap;
      logic emit_repeat;
      logic up_read;
      logic up_eval;
      logic walk_start;
      logic walk_step;
      logic walk_flush;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] operation;
      logic       policy_ok;
      logic       hold_enabled;
      logic       repeat_enabled;
      logic       walk_last;
   } ctl_status_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DISPATCH,
      CTL_UP_EVAL,
      CTL_WALK,
      CTL_FLUSH,
      CTL_FINISH
   } ctl_state_type;

endpackage

// ===== sv/kth_ram.sv =====
`timescale 1ns / 1ps

module kth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kth_controller.sv =====
`timescale 1ns / 1ps

module kth_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  kth_pkg::ctl_status_type  status,
   output kth_pkg::ctl_cmd_type     cmd,
   output logic                     busy
);

   kth_pkg::ctl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kth_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         kth_pkg::CTL_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = kth_pkg::CTL_DISPATCH;
            end
         end
         kth_pkg::CTL_DISPATCH: begin
            state_in = kth_pkg::CTL_IDLE;
            if (status.operation == kth_pkg::OP_TICK) begin
               cmd.walk_start = 1'b1;
               state_in       = kth_pkg::CTL_WALK;
            end else if (status.policy_ok) begin
               case (status.operation)
                  kth_pkg::OP_DOWN: begin
                     if (status.hold_enabled) begin
                        cmd.slot_write = 1'b1;
                     end else begin
                        cmd.emit_tap = 1'b1;
                     end
                  end
                  kth_pkg::OP_REPEAT: begin
                     cmd.emit_repeat = status.repeat_enabled && !status.hold_enabled;
                  end
                  kth_pkg::OP_UP: begin
                     cmd.up_read = 1'b1;
                     state_in    = kth_pkg::CTL_UP_EVAL;
                  end
                  default: begin
                     state_in = kth_pkg::CTL_IDLE;
                  end
               endcase
            end
         end
         kth_pkg::CTL_UP_EVAL: begin
            cmd.up_eval = 1'b1;
            state_in    = kth_pkg::CTL_IDLE;
         end
         // issue one slot read per cycle
         kth_pkg::CTL_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = kth_pkg::CTL_FLUSH;
            end
         end
         // last slot is checked here
         kth_pkg::CTL_FLUSH: begin
            state_in = kth_pkg::CTL_FINISH;
         end
         kth_pkg::CTL_FINISH: begin
            cmd.walk_flush = 1'b1;
            state_in       = kth_pkg::CTL_IDLE;
         end
         default: begin
            state_in = kth_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/kth_datapath.sv =====
`timescale 1ns / 1ps

module kth_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  kth_pkg::req_type         req_data,
   input  kth_pkg::ctl_cmd_type     cmd,
   output kth_pkg::ctl_status_type  status,
   output kth_pkg::rsp_type         rsp_data,
   output logic                     rsp_strobe
);

   kth_pkg::req_type   req_ff, req_in;
   logic [kth_pkg::SLOT_COUNT-1:0] active_ff, active_in;
   logic [kth_pkg::SLOT_COUNT-1:0] done_ff, done_in;
   logic [kth_pkg::IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [kth_pkg::IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic                           eval_vld_ff, eval_vld_in;
   kth_pkg::rsp_type   pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   kth_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   kth_pkg::slot_type         wr_slot;
   kth_pkg::slot_type         rd_slot;
   logic [kth_pkg::IDX_W-1:0] key_idx;
   logic [kth_pkg::IDX_W-1:0] ram_rd_addr;
   logic                      not_back;
   logic [31:0]               elapsed;
   logic                      due;
   logic                      hit;
   kth_pkg::rsp_type          hold_rsp;

   assign key_idx = req_ff.key[kth_pkg::IDX_W-1:0];

   // record written on a hold-enabled key down
   always_comb begin
      wr_slot.press_start = req_ff.now_ms;
      wr_slot.tap_action  = req_ff.tap_action;
      wr_slot.tap_value   = req_ff.tap_value;
      wr_slot.hold_action = req_ff.hold_action;
      wr_slot.hold_value  = req_ff.hold_value;
      wr_slot.threshold   = req_ff.hold_threshold_ms;
   end

   assign ram_rd_addr = cmd.up_read ? key_idx : rd_idx_ff;

   kth_ram #(
      .WIDTH ($bits(kth_pkg::slot_type)),
      .DEPTH (kth_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.slot_write),
      .wr_addr (key_idx),
      .wr_data (wr_slot),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_slot)
   );

   // elapsed time, zero when the clock went back
   assign not_back = req_ff.now_ms >= rd_slot.press_start;
   assign elapsed  = not_back ? (req_ff.now_ms - rd_slot.press_start) : 32'd0;
   assign due      = elapsed >= {16'd0, rd_slot.threshold};
   assign hit      = eval_vld_ff && active_ff[eval_idx_ff] && !done_ff[eval_idx_ff] && due;

   always_comb begin
      hold_rsp.gesture       = rd_slot.hold_action;
      hold_rsp.gesture_value = rd_slot.hold_value;
      hold_rsp.press_kind    = kth_pkg::KIND_HOLD;
      hold_rsp.last          = 1'b0;
   end

   // status to the controller
   always_comb begin
      status.operation      = req_ff.operation;
      status.policy_ok      = req_ff.policy_valid && (int'(req_ff.key) < kth_pkg::SLOT_COUNT);
      status.hold_enabled   = req_ff.hold_enabled;
      status.repeat_enabled = req_ff.repeat_enabled;
      status.walk_last      = rd_idx_ff == kth_pkg::IDX_W'(kth_pkg::SLOT_COUNT - 1);
   end

   // next values
   always_comb begin
      req_in        = req_ff;
      active_in     = active_ff;
      done_in       = done_ff;
      rd_idx_in     = rd_idx_ff;
      eval_idx_in   = rd_idx_ff;
      eval_vld_in   = cmd.walk_step;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      if (cmd.load) begin
         req_in = req_data;
      end

      // press starts or restarts
      if (cmd.slot_write) begin
         active_in[key_idx] = 1'b1;
         done_in[key_idx]   = 1'b0;
      end

      // immediate tap or repeat from the item itself
      if ((cmd.emit_tap || cmd.emit_repeat) && req_ff.tap_action != 8'd0) begin
         rsp_in.gesture       = req_ff.tap_action;
         rsp_in.gesture_value = req_ff.tap_value;
         rsp_in.press_kind    = cmd.emit_repeat ? kth_pkg::KIND_REPEAT : kth_pkg::KIND_TAP;
         rsp_in.last          = 1'b1;
         rsp_strobe_in        = 1'b1;
      end

      // key up releases the slot, tap only if no hold fired
      if (cmd.up_eval && active_ff[key_idx]) begin
         active_in[key_idx] = 1'b0;
         done_in[key_idx]   = 1'b0;
         if (!done_ff[key_idx] && rd_slot.tap_action != 8'd0) begin
            rsp_in.gesture       = rd_slot.tap_action;
            rsp_in.gesture_value = rd_slot.tap_value;
            rsp_in.press_kind    = kth_pkg::KIND_TAP;
            rsp_in.last          = 1'b1;
            rsp_strobe_in        = 1'b1;
         end
      end

      // walk read pointer
      if (cmd.walk_start) begin
         rd_idx_in = '0;
      end else if (cmd.walk_step) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      // hold check; a hit pushes out the held result as not last
      if (hit) begin
         done_in[eval_idx_ff] = 1'b1;
         if (rd_slot.hold_action != 8'd0) begin
            if (pend_vld_ff) begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b0;
               rsp_strobe_in = 1'b1;
            end
            pend_in     = hold_rsp;
            pend_vld_in = 1'b1;
         end
      end

      // end of walk: the held result is the last one
      if (cmd.walk_flush && pend_vld_ff) begin
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         rsp_strobe_in = 1'b1;
         pend_vld_in   = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         done_ff       <= '0;
         eval_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rd_idx_ff     <= '0;
      end else begin
         active_ff     <= active_in;
         done_ff       <= done_in;
         eval_vld_ff   <= eval_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      eval_idx_ff <= eval_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

// ===== sv/key_tap_hold_classifier_core.sv =====
`timescale 1ns / 1ps
// key down or repeat: busy in DISPATCH only, the result is registered there
// key up: busy in DISPATCH, which reads the slot, and UP_EVAL, which registers the tap
// tick: slot RAM read one key per cycle in WALK, then FLUSH, FINISH; start waits while busy
// tick hold results are strobed when the next hit is found, the final one in the first idle cycle
// synchronous reset clears the controller and the active and hold-done flags; slot RAM is
// not cleared and its data is only used for active slots; results cannot be stalled

module key_tap_hold_classifier_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  kth_pkg::req_type  req_data,
   output kth_pkg::rsp_type  rsp_data,
   output logic              rsp_strobe
);

   kth_pkg::ctl_cmd_type    cmd;
   kth_pkg::ctl_status_type status;

   // sequencer
   kth_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // slot store, flags and result registers
   kth_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule
